[rtl/mpk_pkg.sv]
`timescale 1ns / 1ps

package mpk_pkg;

    // Element codes: bit 0 is the dit paddle, bit 1 the dah paddle
    localparam logic [1:0] EL_NONE = 2'd0;
    localparam logic [1:0] EL_DIT  = 2'h1;
    localparam logic [1:0] EL_DAH  = 2'h2;
    localparam logic [1:0] EL_BOTH = 2'd3;

    // Input item kinds
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_WAKE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYER_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDLE_REVERSE = 1'd1;

    typedef enum logic [1:0] {
        MODE_ULTIMATE = 2'd0,
        MODE_PLAIN    = 2'd1,
        MODE_IAMBIC_A = 2'd2,
        MODE_IAMBIC_B = 2'd3
    } keyer_mode_t;

endpackage

[rtl/mpk_channels.sv]
`timescale 1ns / 1ps

// Input item channel: poll ticks and wakeups
interface mpk_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic       left_pressed;
    logic       right_pressed;
    logic       keyer_busy;
    logic [1:0] wake_request;

    modport source (output valid, kind, left_pressed, right_pressed, keyer_busy,
                    wake_request, input ready);
    modport sink (input valid, kind, left_pressed, right_pressed, keyer_busy,
                  wake_request, output ready);
endinterface

// Result channel: one element per transaction
interface mpk_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] element;

    modport source (output valid, element, input ready);
    modport sink (input valid, element, output ready);
endinterface

// Configuration write channel
interface mpk_cfg_if;
    import mpk_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/morse_paddle_keyer_logic.sv]
`timescale 1ns / 1ps
// The input register feeds one pass of mode logic into the result register,
// which holds until the result is taken. One input item is taken per clock
// while the result side does not stall.
// Reset (rst_n, asynchronous, active low): ultimate mode, normal paddles, no
// pending request, memory enabled, dit polled first, both stages empty.
module morse_paddle_keyer_logic (
    input logic clk,
    input logic rst_n,
    mpk_in_if.sink    in_ch,
    mpk_out_if.source out_ch,
    mpk_cfg_if.sink   cfg
);
    import mpk_pkg::*;

    // Configuration
    keyer_mode_t keyer_mode_reg;
    logic        paddle_reverse_reg;

    // Input register
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic       in_left_reg;
    logic       in_right_reg;
    logic       in_busy_reg;
    logic [1:0] in_wake_reg;

    // Result register
    logic       out_valid_reg;
    logic [1:0] out_element_reg;

    // Keyer state
    logic [1:0] pending_request_reg, pending_request_next;
    logic [1:0] ultimate_last_reg, ultimate_last_next;
    logic       memory_enabled_reg, memory_enabled_next;
    logic       plain_poll_dah_reg, plain_poll_dah_next;
    logic       mode_a_poll_dah_reg, mode_a_poll_dah_next;
    logic       mode_a_prev_dit_reg, mode_a_prev_dit_next;
    logic       mode_a_cur_dit_reg, mode_a_cur_dit_next;

    logic       advance;
    logic       process;
    logic [1:0] pad;
    logic [1:0] el;
    logic       cur_dit;

    // Stage hand-off
    assign advance      = !out_valid_reg || out_ch.ready;
    assign process      = in_valid_reg && advance;
    assign in_ch.ready  = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.element = out_element_reg;

    // Contact to paddle code mapping
    assign pad = paddle_reverse_reg ? {in_left_reg, in_right_reg}
                                    : {in_right_reg, in_left_reg};
    assign cur_dit = pad[0];

    // Mode logic: one pass per item
    always_comb
    begin
        el                   = EL_NONE;
        pending_request_next = pending_request_reg;
        ultimate_last_next   = ultimate_last_reg;
        memory_enabled_next  = memory_enabled_reg;
        plain_poll_dah_next  = plain_poll_dah_reg;
        mode_a_poll_dah_next = mode_a_poll_dah_reg;
        mode_a_prev_dit_next = mode_a_prev_dit_reg;
        mode_a_cur_dit_next  = mode_a_cur_dit_reg;
        if (in_kind_reg == KIND_WAKE)
        begin
            pending_request_next = in_wake_reg;
        end
        else
        begin
            unique case (keyer_mode_reg)
                MODE_ULTIMATE:
                begin
                    if (in_busy_reg)
                    begin
                        if (memory_enabled_reg && pending_request_reg != EL_NONE
                            && pending_request_reg != EL_BOTH
                            && pending_request_reg == pad)
                        begin
                            el                   = pad;
                            ultimate_last_next   = pad;
                            pending_request_next = EL_NONE;
                            memory_enabled_next  = 1'b0;
                        end
                    end
                    else if (pad == EL_NONE)
                    begin
                        ultimate_last_next  = EL_NONE;
                        memory_enabled_next = 1'b1;
                    end
                    else if (pad == EL_DIT || pad == EL_DAH)
                    begin
                        ultimate_last_next = pad;
                        el                 = pad;
                    end
                    else if (ultimate_last_reg == EL_DIT)
                    begin
                        el = EL_DAH;
                    end
                    else if (ultimate_last_reg == EL_DAH)
                    begin
                        el = EL_DIT;
                    end
                end
                MODE_PLAIN:
                begin
                    if (!in_busy_reg)
                    begin
                        el = pad & (plain_poll_dah_reg ? EL_DAH : EL_DIT);
                        plain_poll_dah_next = !plain_poll_dah_reg;
                    end
                end
                MODE_IAMBIC_A:
                begin
                    if (in_busy_reg)
                    begin
                        if (pending_request_reg != EL_NONE)
                        begin
                            if (pending_request_reg == EL_DIT)
                            begin
                                mode_a_cur_dit_next  = cur_dit;
                                mode_a_prev_dit_next = cur_dit;
                                if (cur_dit && !mode_a_prev_dit_reg)
                                begin
                                    el                   = EL_DIT;
                                    pending_request_next = EL_NONE;
                                    mode_a_poll_dah_next = 1'b1;
                                end
                            end
                            else
                            begin
                                mode_a_prev_dit_next = mode_a_cur_dit_reg;
                            end
                        end
                    end
                    else
                    begin
                        mode_a_prev_dit_next = 1'b1;
                        el = pad & (mode_a_poll_dah_reg ? EL_DAH : EL_DIT);
                        mode_a_poll_dah_next = !mode_a_poll_dah_reg;
                    end
                end
                MODE_IAMBIC_B:
                begin
                    if (in_busy_reg)
                    begin
                        if (pending_request_reg == EL_DIT && pad[0])
                        begin
                            el                   = EL_DIT;
                            pending_request_next = EL_NONE;
                        end
                        else if (pending_request_reg == EL_DAH && pad[1])
                        begin
                            el                   = EL_DAH;
                            pending_request_next = EL_NONE;
                        end
                    end
                    else if (pad == EL_DIT || pad == EL_DAH)
                    begin
                        el = pad;
                    end
                end
                default:
                begin
                    el = EL_NONE;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyer_mode_reg     <= MODE_ULTIMATE;
            paddle_reverse_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_KEYER_MODE:     keyer_mode_reg     <= keyer_mode_t'(cfg.data);
                CFG_PADDLE_REVERSE: paddle_reverse_reg <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_kind_reg  <= in_ch.kind;
            in_left_reg  <= in_ch.left_pressed;
            in_right_reg <= in_ch.right_pressed;
            in_busy_reg  <= in_ch.keyer_busy;
            in_wake_reg  <= in_ch.wake_request;
        end
    end

    // Result register and keyer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            pending_request_reg <= EL_NONE;
            ultimate_last_reg   <= EL_NONE;
            memory_enabled_reg  <= 1'b1;
            plain_poll_dah_reg  <= 1'b0;
            mode_a_poll_dah_reg <= 1'b0;
            mode_a_prev_dit_reg <= 1'b1;
            mode_a_cur_dit_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= process && (el != EL_NONE);
            if (process)
            begin
                pending_request_reg <= pending_request_next;
                ultimate_last_reg   <= ultimate_last_next;
                memory_enabled_reg  <= memory_enabled_next;
                plain_poll_dah_reg  <= plain_poll_dah_next;
                mode_a_poll_dah_reg <= mode_a_poll_dah_next;
                mode_a_prev_dit_reg <= mode_a_prev_dit_next;
                mode_a_cur_dit_reg  <= mode_a_cur_dit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_element_reg <= el;
        end
    end

    // Checks
    a_element_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_element_reg == EL_DIT || out_element_reg == EL_DAH))
        else $error("result element is neither dit nor dah");

    a_wake_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_kind_reg == KIND_WAKE) |=> !out_valid_reg)
        else $error("wakeup item produced a result");

    a_b_idle_both: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_kind_reg == KIND_POLL && keyer_mode_reg == MODE_IAMBIC_B
         && !in_busy_reg && pad == EL_BOTH) |=> !out_valid_reg)
        else $error("iambic B gave an element with both paddles while idle");

    a_plain_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_kind_reg == KIND_POLL && keyer_mode_reg == MODE_PLAIN
         && !in_busy_reg) |=> (plain_poll_dah_reg != $past(plain_poll_dah_reg)))
        else $error("plain iambic poll toggle did not flip");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mpk_pkg::*;

    localparam int HOLD_OFF_CYCLES          = 80;
    localparam int SETTLE_CYCLES            = 4;
    localparam int DRAIN_GUARD              = 5000;
    localparam int RANDOM_POLLS_PER_PHASE   = 102;

    // One input item as carried by the input channel
    typedef struct packed {
        logic       kind;
        logic       left_pressed;
        logic       right_pressed;
        logic       keyer_busy;
        logic [1:0] wake_request;
    } paddle_item_t;

    logic clk;
    logic rst_n;

    mpk_in_if  in_ch();
    mpk_out_if out_ch();
    mpk_cfg_if cfg_ch();

    morse_paddle_keyer_logic dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // Expected elements, oldest first
    logic [1:0] expected_elements[$];
    int         error_count = 0;
    bit         no_idle = 1'b0;
    bit         hold_off_req = 1'b0;

    // Keyer decision state, as after reset
    keyer_mode_t mode_reg     = MODE_ULTIMATE;
    logic        reverse_reg  = 1'b0;
    logic [1:0]  pending_req  = EL_NONE;
    logic [1:0]  ult_last     = EL_NONE;
    logic        mem_enabled  = 1'b1;
    logic        plain_dah    = 1'b0;
    logic        a_poll_dah   = 1'b0;
    logic        a_prev_dit   = 1'b1;
    logic        a_cur_dit    = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Mostly back-to-back, sometimes a short pause, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Contacts to paddle code: bit 0 dit, bit 1 dah
    function automatic logic [1:0] map_paddles(logic left, logic right);
        if (reverse_reg)
            return {left, right};
        return {right, left};
    endfunction

    // Work out the element, if any, that one accepted item gives
    task automatic decide_element(input paddle_item_t it);
        logic [1:0] pad;
        logic [1:0] el;
        el = EL_NONE;
        if (it.kind == KIND_WAKE)
        begin
            pending_req = it.wake_request;
            return;
        end
        pad = map_paddles(it.left_pressed, it.right_pressed);
        case (mode_reg)
            MODE_ULTIMATE:
            begin
                if (it.keyer_busy)
                begin
                    if (pending_req != EL_NONE && mem_enabled &&
                        ((pending_req == EL_DIT && pad == EL_DIT) ||
                         (pending_req == EL_DAH && pad == EL_DAH)))
                    begin
                        el = pad;
                        ult_last = pad;
                        pending_req = EL_NONE;
                        mem_enabled = 1'b0;
                    end
                end
                else if (pad == EL_NONE)
                begin
                    ult_last = EL_NONE;
                    mem_enabled = 1'b1;
                end
                else if (pad == EL_DIT || pad == EL_DAH)
                begin
                    ult_last = pad;
                    el = pad;
                end
                else if (ult_last == EL_DIT)
                    el = EL_DAH;
                else if (ult_last == EL_DAH)
                    el = EL_DIT;
            end
            MODE_PLAIN:
            begin
                if (!it.keyer_busy)
                begin
                    el = pad & (plain_dah ? EL_DAH : EL_DIT);
                    plain_dah = ~plain_dah;
                end
            end
            MODE_IAMBIC_A:
            begin
                if (it.keyer_busy)
                begin
                    if (pending_req != EL_NONE)
                    begin
                        if (pending_req == EL_DIT)
                        begin
                            a_cur_dit = pad[0];
                            // dit only on a fresh press of the dit paddle
                            if (a_cur_dit && !a_prev_dit)
                            begin
                                el = EL_DIT;
                                pending_req = EL_NONE;
                                a_poll_dah = 1'b1;
                            end
                        end
                        a_prev_dit = a_cur_dit;
                    end
                end
                else
                begin
                    a_prev_dit = 1'b1;
                    el = pad & (a_poll_dah ? EL_DAH : EL_DIT);
                    a_poll_dah = ~a_poll_dah;
                end
            end
            default:
            begin
                if (it.keyer_busy)
                begin
                    if (pending_req == EL_DIT && pad[0])
                    begin
                        el = EL_DIT;
                        pending_req = EL_NONE;
                    end
                    else if (pending_req == EL_DAH && pad[1])
                    begin
                        el = EL_DAH;
                        pending_req = EL_NONE;
                    end
                end
                else if (pad == EL_DIT || pad == EL_DAH)
                    el = pad;
            end
        endcase
        if (el != EL_NONE)
            expected_elements.push_back(el);
    endtask

    function automatic paddle_item_t poll_item(logic left, logic right, logic busy);
        paddle_item_t it;
        it.kind          = KIND_POLL;
        it.left_pressed  = left;
        it.right_pressed = right;
        it.keyer_busy    = busy;
        it.wake_request  = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // Paddle and busy fields of a wakeup are don't-care, so scramble them
    function automatic paddle_item_t wake_item(logic [1:0] req);
        paddle_item_t it;
        it.kind          = KIND_WAKE;
        it.left_pressed  = 1'($urandom_range(0, 1));
        it.right_pressed = 1'($urandom_range(0, 1));
        it.keyer_busy    = 1'($urandom_range(0, 1));
        it.wake_request  = req;
        return it;
    endfunction

    // Offer one item and wait for the transaction
    task automatic send_item(input paddle_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= it.kind;
        in_ch.left_pressed  <= it.left_pressed;
        in_ch.right_pressed <= it.right_pressed;
        in_ch.keyer_busy    <= it.keyer_busy;
        in_ch.wake_request  <= it.wake_request;
        do @(posedge clk); while (!in_ch.ready);
        decide_element(it);
    endtask

    // Stop offering and let the block empty out
    task automatic settle();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_elements.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_KEYER_MODE)
            mode_reg = keyer_mode_t'(value);
        else
            reverse_reg = value[0];
    endtask

    // Upper data bit of the reverse register is unused; randomize it anyway
    task automatic set_config(input keyer_mode_t mode, input logic rev);
        write_reg(CFG_KEYER_MODE, mode);
        write_reg(CFG_PADDLE_REVERSE, {1'($urandom_range(0, 1)), rev});
    endtask

    task automatic test_ultimate();
        send_item(poll_item(1'b1, 1'b0, 1'b0));   // dit
        send_item(poll_item(1'b1, 1'b1, 1'b0));   // squeeze after dit: dah
        send_item(poll_item(1'b0, 1'b1, 1'b0));   // dah
        send_item(poll_item(1'b1, 1'b1, 1'b0));   // squeeze after dah: dit
        send_item(poll_item(1'b0, 1'b0, 1'b0));   // release clears last, rearms memory
        send_item(poll_item(1'b1, 1'b1, 1'b0));   // squeeze with no last: nothing
        send_item(wake_item(EL_DIT));
        send_item(poll_item(1'b1, 1'b0, 1'b1));   // memory dit while busy
        send_item(wake_item(EL_DAH));
        send_item(poll_item(1'b0, 1'b1, 1'b1));   // memory used up: nothing
        send_item(poll_item(1'b0, 1'b0, 1'b0));
        send_item(wake_item(EL_BOTH));
        send_item(poll_item(1'b1, 1'b1, 1'b1));   // request both never matches
    endtask

    task automatic test_reverse();
        set_config(MODE_ULTIMATE, 1'b1);
        send_item(poll_item(1'b1, 1'b0, 1'b0));   // left is dah
        send_item(poll_item(1'b0, 1'b1, 1'b0));   // right is dit
        set_config(MODE_ULTIMATE, 1'b0);
    endtask

    task automatic test_plain();
        set_config(MODE_PLAIN, 1'b0);
        send_item(poll_item(1'b1, 1'b1, 1'b0));
        send_item(poll_item(1'b1, 1'b1, 1'b0));
        send_item(poll_item(1'b1, 1'b1, 1'b1));   // busy: no toggle, nothing
    endtask

    task automatic test_iambic_a();
        set_config(MODE_IAMBIC_A, 1'b0);
        send_item(wake_item(EL_DIT));
        send_item(poll_item(1'b0, 1'b0, 1'b1));   // dit paddle open while busy
        send_item(poll_item(1'b1, 1'b0, 1'b1));   // fresh dit press
        send_item(wake_item(EL_DAH));
        send_item(poll_item(1'b1, 1'b0, 1'b1));   // non-dit request reloads previous dit
        send_item(poll_item(1'b1, 1'b1, 1'b0));
    endtask

    task automatic test_iambic_b();
        set_config(MODE_IAMBIC_B, 1'b0);
        send_item(poll_item(1'b1, 1'b1, 1'b0));   // idle squeeze: nothing
        send_item(wake_item(EL_DAH));
        send_item(poll_item(1'b0, 1'b1, 1'b1));
        send_item(poll_item(1'b1, 1'b0, 1'b0));
    endtask

    // Receiver holds off while single-paddle polls keep coming
    task automatic test_pressure();
        logic left;
        set_config(MODE_ULTIMATE, 1'b0);
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        repeat (16)
        begin
            left = 1'($urandom_range(0, 1));
            send_item(poll_item(left, ~left, 1'b0));
        end
        no_idle = 1'b0;
    endtask

    // A wakeup, a few busy polls, then a few idle ones; sometimes stray items
    task automatic send_phrase(inout int polls);
        int         pick;
        int         n;
        logic [1:0] req;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            pick = $urandom_range(0, 9);
            req = (pick < 4) ? EL_DIT : (pick < 8) ? EL_DAH : (pick < 9) ? EL_NONE : EL_BOTH;
            send_item(wake_item(req));
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                send_item(poll_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'b1));
                polls++;
            end
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                send_item(poll_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'b0));
                polls++;
            end
        end
        else if ($urandom_range(0, 1))
            send_item(wake_item(2'($urandom_range(0, 3))));
        else
        begin
            send_item(poll_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
            polls++;
        end
    endtask

    task automatic test_random();
        int polls;
        for (int m = 0; m < 4; m++)
        begin
            for (int rv = 0; rv < 2; rv++)
            begin
                set_config(keyer_mode_t'(m), 1'(rv));
                no_idle = (m == 2 && rv == 1) || ($urandom_range(0, 3) == 0);
                polls = 0;
                while (polls < RANDOM_POLLS_PER_PHASE)
                    send_phrase(polls);
                no_idle = 1'b0;
            end
        end
    endtask

    // Result side: random stalls, plus the long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0 && !no_idle)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each result transaction with the oldest expected element
    always @(posedge clk)
    begin
        logic [1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_elements.size() == 0)
            begin
                $error("element: none expected, actual %0d", out_ch.element);
                error_count++;
            end
            else
            begin
                want = expected_elements.pop_front();
                if (out_ch.element !== want)
                begin
                    $error("element: expected %0d, actual %0d", want, out_ch.element);
                    error_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.kind          <= KIND_POLL;
        in_ch.left_pressed  <= 1'b0;
        in_ch.right_pressed <= 1'b0;
        in_ch.keyer_busy    <= 1'b0;
        in_ch.wake_request  <= EL_NONE;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_KEYER_MODE;
        cfg_ch.data         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ultimate();
        test_reverse();
        test_plain();
        test_iambic_a();
        test_iambic_b();
        test_pressure();
        test_random();

        settle();
        if (expected_elements.size() != 0)
        begin
            $error("element: %0d expected results never arrived", expected_elements.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
